// ----- rtl/core/mrc_pkg.sv -----
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types, codes and helper functions of the Modbus response checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

	localparam int MAX_FRAME_DEF = 260;
	localparam int COUNT_W       = 18;
	localparam logic [2:0] HDR_LEN_RST = 3'd7;

	typedef enum logic [3:0] {
		ST_OK         = 4'd0,
		ST_EXCEPTION  = 4'd1,
		ST_BAD_EXC    = 4'd2,
		ST_TXN        = 4'd3,
		ST_PROTOCOL   = 4'd4,
		ST_LENGTH     = 4'd5,
		ST_BAD_FUNC   = 4'd6,
		ST_FUNC_MISM  = 4'd7,
		ST_QTY_MISM   = 4'd8
	} status_t;

	localparam logic OP_REQUEST  = 1'b0;
	localparam logic OP_RESPONSE = 1'b1;

	localparam logic KIND_LENGTH  = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	localparam logic [7:0] FC_READ_COILS     = 8'h01;
	localparam logic [7:0] FC_READ_DISCRETE  = 8'h02;
	localparam logic [7:0] FC_READ_HOLDING   = 8'h03;
	localparam logic [7:0] FC_READ_INPUT     = 8'h04;
	localparam logic [7:0] FC_WRITE_COIL     = 8'h05;
	localparam logic [7:0] FC_WRITE_REG      = 8'h06;
	localparam logic [7:0] FC_READ_EXC_ST    = 8'h07;
	localparam logic [7:0] FC_DIAG           = 8'h08;
	localparam logic [7:0] FC_WRITE_COILS    = 8'h0F;
	localparam logic [7:0] FC_WRITE_REGS     = 8'h10;
	localparam logic [7:0] FC_READ_FILE      = 8'h14;
	localparam logic [7:0] FC_MASK_WRITE     = 8'h16;
	localparam logic [7:0] FC_RW_REGS        = 8'h17;
	localparam logic [7:0] FC_READ_FIFO      = 8'h18;
	localparam logic [7:0] FC_ENCAP          = 8'h2B;

	typedef struct packed {
		logic [15:0] req_txn;
		logic [7:0]  req_func;
		logic [15:0] req_qty;
		logic        txn_bad;
		logic        proto_bad;
		logic [7:0]  rsp_func;
		logic [7:0]  rsp_byte_one;
		logic [15:0] rsp_word_three;
	} cap_t;

	function automatic logic func_valid(input logic [7:0] f);
		logic ok;
		case (f)
			FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
			FC_WRITE_COIL, FC_WRITE_REG, FC_READ_EXC_ST, FC_DIAG,
			FC_WRITE_COILS, FC_WRITE_REGS, FC_READ_FILE, FC_MASK_WRITE,
			FC_RW_REGS, FC_READ_FIFO, FC_ENCAP: ok = 1'b1;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	function automatic logic [15:0] ceil_bytes(input logic [15:0] bits);
		return {3'd0, bits[15:3]} + {15'd0, |bits[2:0]};
	endfunction

	function automatic logic [COUNT_W-1:0] calc_reply_len(input logic [7:0] func,
		input logic [15:0] qty, input logic [2:0] hl);
		logic [COUNT_W-1:0] body;
		case (func)
			FC_READ_COILS, FC_READ_DISCRETE:
				body = COUNT_W'(ceil_bytes(qty)) + COUNT_W'(2);
			FC_READ_HOLDING, FC_READ_INPUT, FC_RW_REGS:
				body = {1'b0, qty, 1'b0} + COUNT_W'(2);
			FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS:
				body = COUNT_W'(5);
			FC_MASK_WRITE:
				body = COUNT_W'(7);
			default:
				body = '0;
		endcase
		return body + COUNT_W'(hl);
	endfunction

endpackage

// ----- rtl/core/mrc_capture.sv -----
// ----------------------------------------------------------------------------
// mrc_capture
// Frame byte counters and field captures; presents the state after the byte.
// ----------------------------------------------------------------------------
module mrc_capture #(
	parameter int MAX_FRAME = mrc_pkg::MAX_FRAME_DEF,
	parameter int IDX_W     = $clog2(MAX_FRAME + 2)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic               opcode,
	input  logic [7:0]         data_byte,
	input  logic               is_last,
	input  logic [2:0]         hdr_len,
	output mrc_pkg::cap_t      cap_nx,
	output logic [IDX_W-1:0]   rsp_len
);
	import mrc_pkg::*;

	localparam logic [IDX_W-1:0] MaxIdx = IDX_W'(MAX_FRAME);

	logic [IDX_W-1:0] req_idx_q, rsp_idx_q;
	logic [IDX_W-1:0] req_idx_nx, rsp_idx_nx;
	logic [IDX_W-1:0] i, h0, h1, h3, h4;
	cap_t             cap_q;

	assign h0 = IDX_W'(hdr_len);
	assign h1 = h0 + IDX_W'(1);
	assign h3 = h0 + IDX_W'(3);
	assign h4 = h0 + IDX_W'(4);

	always_comb begin
		cap_nx     = cap_q;
		req_idx_nx = req_idx_q;
		rsp_idx_nx = rsp_idx_q;
		rsp_len    = rsp_idx_q;
		i          = (opcode == OP_REQUEST) ? req_idx_q : rsp_idx_q;
		if (opcode == OP_REQUEST) begin
			if (i == '0) begin
				cap_nx.req_txn  = '0;
				cap_nx.req_func = '0;
				cap_nx.req_qty  = '0;
				rsp_idx_nx      = '0;
			end
			if (i < MaxIdx) begin
				if (i == IDX_W'(0)) cap_nx.req_txn[15:8] = data_byte;
				if (i == IDX_W'(1)) cap_nx.req_txn[7:0]  = data_byte;
				if (i == h0) cap_nx.req_func = data_byte;
				if (i == h3) cap_nx.req_qty[15:8] = data_byte;
				if (i == h4) cap_nx.req_qty[7:0]  = data_byte;
			end
			if (i <= MaxIdx) req_idx_nx = i + IDX_W'(1);
			if (is_last) req_idx_nx = '0;
		end else begin
			if (i == '0) begin
				cap_nx.txn_bad        = 1'b0;
				cap_nx.proto_bad      = 1'b0;
				cap_nx.rsp_func       = '0;
				cap_nx.rsp_byte_one   = '0;
				cap_nx.rsp_word_three = '0;
			end
			if (i < MaxIdx) begin
				if (i == IDX_W'(0) && data_byte != cap_q.req_txn[15:8]) cap_nx.txn_bad = 1'b1;
				if (i == IDX_W'(1) && data_byte != cap_q.req_txn[7:0]) cap_nx.txn_bad = 1'b1;
				if ((i == IDX_W'(2) || i == IDX_W'(3)) && data_byte != 8'h00)
					cap_nx.proto_bad = 1'b1;
				if (i == h0) cap_nx.rsp_func     = data_byte;
				if (i == h1) cap_nx.rsp_byte_one = data_byte;
				if (i == h3) cap_nx.rsp_word_three[15:8] = data_byte;
				if (i == h4) cap_nx.rsp_word_three[7:0]  = data_byte;
			end
			if (i <= MaxIdx) rsp_idx_nx = i + IDX_W'(1);
			rsp_len = rsp_idx_nx;
			if (is_last) rsp_idx_nx = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_idx_q <= '0;
			rsp_idx_q <= '0;
			cap_q     <= '0;
		end else if (fire) begin
			req_idx_q <= req_idx_nx;
			rsp_idx_q <= rsp_idx_nx;
			cap_q     <= cap_nx;
		end
	end

endmodule

// ----- rtl/core/mrc_verdict.sv -----
// ----------------------------------------------------------------------------
// mrc_verdict
// Forms the length report or the response verdict from the captured fields.
// ----------------------------------------------------------------------------
module mrc_verdict #(
	parameter int IDX_W = $clog2(mrc_pkg::MAX_FRAME_DEF + 2)
) (
	input  logic                          kind,
	input  mrc_pkg::cap_t                 cap,
	input  logic [IDX_W-1:0]              rsp_len,
	input  logic [2:0]                    hdr_len,
	output logic [3:0]                    status,
	output logic [7:0]                    exc_code,
	output logic [mrc_pkg::COUNT_W-1:0]   count
);
	import mrc_pkg::*;

	logic [COUNT_W-1:0] exp_len, len;
	logic               exc_form, code_ok;
	logic [15:0]        req_n, res_n;
	status_t            st;

	assign exp_len = calc_reply_len(cap.req_func, cap.req_qty, hdr_len);
	assign len     = COUNT_W'(rsp_len);

	assign exc_form = cap.rsp_func[7] &&
		(len == COUNT_W'(hdr_len) + COUNT_W'(2)) &&
		!cap.req_func[7] && (cap.req_func[6:0] == cap.rsp_func[6:0]);
	assign code_ok = (cap.rsp_byte_one inside {[8'd1:8'd11]}) && (cap.rsp_byte_one != 8'd9);

	always_comb begin
		case (cap.rsp_func)
			FC_READ_COILS, FC_READ_DISCRETE: begin
				req_n = ceil_bytes(cap.req_qty);
				res_n = {8'd0, cap.rsp_byte_one};
			end
			FC_READ_HOLDING, FC_READ_INPUT, FC_RW_REGS: begin
				req_n = cap.req_qty;
				res_n = {9'd0, cap.rsp_byte_one[7:1]};
			end
			FC_WRITE_COILS, FC_WRITE_REGS: begin
				req_n = cap.req_qty;
				res_n = cap.rsp_word_three;
			end
			FC_WRITE_COIL, FC_WRITE_REG: begin
				req_n = 16'd1;
				res_n = 16'd1;
			end
			default: begin
				req_n = '0;
				res_n = '0;
			end
		endcase
	end

	always_comb begin
		st       = ST_OK;
		exc_code = '0;
		count    = '0;
		if (kind == KIND_LENGTH) begin
			count = exp_len;
		end else if (cap.txn_bad) begin
			st = ST_TXN;
		end else if (cap.proto_bad) begin
			st = ST_PROTOCOL;
		end else if (exc_form) begin
			if (code_ok) begin
				st       = ST_EXCEPTION;
				exc_code = cap.rsp_byte_one;
			end else begin
				st = ST_BAD_EXC;
			end
		end else if (len != exp_len) begin
			st = ST_LENGTH;
		end else if (!func_valid(cap.rsp_func)) begin
			st = ST_BAD_FUNC;
		end else if (cap.req_func != cap.rsp_func) begin
			st = ST_FUNC_MISM;
		end else if (req_n != res_n) begin
			st = ST_QTY_MISM;
		end else begin
			count = COUNT_W'(req_n);
		end
	end

	assign status = st;

endmodule

// ----- rtl/core/modbus_response_checker.sv -----
// Path: the item that closes a frame passes the input stage registers, then
// its result item is registered in the output registers and presented.
// Throughput: one input item per cycle, unless a frame's last item waits on
// a result not yet taken; capture counters and verdict logic set this pace.
// Reset: arst_n clears all counters, captures and valid flags at once and
// sets the header length to 7; in_ready is high once reset is released.
// ----------------------------------------------------------------------------
// modbus_response_checker
// Checks Modbus replies against requests, reports reply lengths; byte items.
// ----------------------------------------------------------------------------
module modbus_response_checker #(
	parameter int MAX_FRAME = mrc_pkg::MAX_FRAME_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          opcode,
	input  logic [7:0]                    data_byte,
	input  logic                          is_last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          result_kind,
	output logic [3:0]                    status,
	output logic [7:0]                    exc_code,
	output logic [mrc_pkg::COUNT_W-1:0]   count
);
	import mrc_pkg::*;

	localparam int IDX_W = $clog2(MAX_FRAME + 2);

	logic [2:0]         hdr_len_q;
	logic               valid_s1, op_s1, last_s1;
	logic [7:0]         byte_s1;
	logic               stall, fire;
	cap_t               cap_nx;
	logic [IDX_W-1:0]   rsp_len;
	logic [3:0]         st_nx;
	logic [7:0]         code_nx;
	logic [COUNT_W-1:0] count_nx;
	logic               out_valid_q, kind_q;
	logic [3:0]         status_q;
	logic [7:0]         code_q;
	logic [COUNT_W-1:0] count_q;

	assign stall    = valid_s1 && last_s1 && out_valid_q && !out_ready;
	assign fire     = valid_s1 && !stall;
	assign in_ready = !valid_s1 || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_len_q <= HDR_LEN_RST;
		end else if (cfg_we) begin
			hdr_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= opcode;
			byte_s1 <= data_byte;
			last_s1 <= is_last;
		end
	end

	mrc_capture #(
		.MAX_FRAME (MAX_FRAME),
		.IDX_W     (IDX_W)
	) u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.opcode    (op_s1),
		.data_byte (byte_s1),
		.is_last   (last_s1),
		.hdr_len   (hdr_len_q),
		.cap_nx    (cap_nx),
		.rsp_len   (rsp_len)
	);

	mrc_verdict #(
		.IDX_W (IDX_W)
	) u_verdict (
		.kind     (op_s1),
		.cap      (cap_nx),
		.rsp_len  (rsp_len),
		.hdr_len  (hdr_len_q),
		.status   (st_nx),
		.exc_code (code_nx),
		.count    (count_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s1) begin
			kind_q   <= (op_s1 == OP_RESPONSE) ? KIND_VERDICT : KIND_LENGTH;
			status_q <= st_nx;
			code_q   <= code_nx;
			count_q  <= count_nx;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign status      = status_q;
	assign exc_code    = code_q;
	assign count       = count_q;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds Modbus request and response bytes into modbus_response_checker under
// random flow control on both sides. A behavioral model of the checker
// predicts every length report and verdict, and each result is compared
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module testbench;
	import mrc_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		logic               kind;
		logic [3:0]         status;
		logic [7:0]         exc;
		logic [COUNT_W-1:0] cnt;
	} report_t;

	localparam logic [7:0] EXC_FLAG       = 8'h80;
	localparam logic [7:0] EXC_CODE_MIN   = 8'd1;
	localparam logic [7:0] EXC_CODE_MAX   = 8'd11;
	localparam logic [7:0] EXC_CODE_SPARE = 8'd9;
	localparam int unsigned SWEEP_BYTES   = 700;

	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               cfg_we         = 1'b0;
	logic [2:0]         cfg_wdata      = HDR_LEN_RST;
	logic               in_valid       = 1'b0;
	logic               in_ready;
	logic               opcode         = OP_REQUEST;
	logic [7:0]         data_byte      = 8'h00;
	logic               is_last        = 1'b0;
	logic               out_valid;
	logic               out_ready      = 1'b1;
	logic               result_kind;
	logic [3:0]         status;
	logic [7:0]         exc_code;
	logic [COUNT_W-1:0] count;

	int unsigned hdr_len        = HDR_LEN_RST;
	int unsigned req_pos        = 0;
	int unsigned rsp_pos        = 0;
	logic [15:0] req_txn        = '0;
	logic [7:0]  req_fc         = '0;
	logic [15:0] req_qty        = '0;
	logic        txn_err        = 1'b0;
	logic        proto_err      = 1'b0;
	logic [7:0]  rsp_fc         = '0;
	logic [7:0]  rsp_count_byte = '0;
	logic [15:0] rsp_qty_word   = '0;

	report_t     awaited_reports[$];
	int unsigned mismatches  = 0;
	int unsigned bytes_sent  = 0;
	int unsigned burst_left  = 0;
	int unsigned ready_style = 0;
	int unsigned ready_hold  = 0;
	int unsigned ready_tick  = 0;

	modbus_response_checker dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.data_byte   (data_byte),
		.is_last     (is_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.status      (status),
		.exc_code    (exc_code),
		.count       (count)
	);

	always #1 clk = ~clk;

	function automatic int unsigned coil_bytes(input logic [15:0] qty);
		return (qty >> 3) + ((qty[2:0] != 3'd0) ? 1 : 0);
	endfunction

	function automatic int unsigned reply_length(input logic [7:0] fc, input logic [15:0] qty,
		input int unsigned hl);
		int unsigned body;
		case (fc)
			FC_READ_COILS, FC_READ_DISCRETE: body = 2 + coil_bytes(qty);
			FC_READ_HOLDING, FC_READ_INPUT, FC_RW_REGS: body = 2 + 2 * qty;
			FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS: body = 5;
			FC_MASK_WRITE: body = 7;
			default: body = 0;
		endcase
		return hl + body;
	endfunction

	task automatic track_frames(input logic op, input logic [7:0] b, input logic last);
		report_t     r;
		int unsigned i;
		int unsigned len;
		int unsigned want;
		int unsigned got;
		bit          listed;
		r = '0;
		want = 0;
		got = 0;
		if (op == OP_REQUEST) begin
			i = req_pos;
			if (i == 0) begin
				req_txn = '0;
				req_fc = '0;
				req_qty = '0;
				rsp_pos = 0;
			end
			if (i < MAX_FRAME_DEF) begin
				if (i == 0) req_txn[15:8] = b;
				if (i == 1) req_txn[7:0] = b;
				if (i == hdr_len) req_fc = b;
				if (i == hdr_len + 3) req_qty[15:8] = b;
				if (i == hdr_len + 4) req_qty[7:0] = b;
			end
			if (i <= MAX_FRAME_DEF) req_pos = i + 1;
			if (last) begin
				req_pos = 0;
				r.kind = KIND_LENGTH;
				r.status = ST_OK;
				r.cnt = COUNT_W'(reply_length(req_fc, req_qty, hdr_len));
				awaited_reports.push_back(r);
			end
		end else begin
			i = rsp_pos;
			if (i == 0) begin
				txn_err = 1'b0;
				proto_err = 1'b0;
				rsp_fc = '0;
				rsp_count_byte = '0;
				rsp_qty_word = '0;
			end
			if (i < MAX_FRAME_DEF) begin
				if (i == 0 && b != req_txn[15:8]) txn_err = 1'b1;
				if (i == 1 && b != req_txn[7:0]) txn_err = 1'b1;
				if ((i == 2 || i == 3) && b != 8'h00) proto_err = 1'b1;
				if (i == hdr_len) rsp_fc = b;
				if (i == hdr_len + 1) rsp_count_byte = b;
				if (i == hdr_len + 3) rsp_qty_word[15:8] = b;
				if (i == hdr_len + 4) rsp_qty_word[7:0] = b;
			end
			if (i <= MAX_FRAME_DEF) rsp_pos = i + 1;
			if (last) begin
				len = rsp_pos;
				rsp_pos = 0;
				case (rsp_fc)
					FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
					FC_WRITE_COIL, FC_WRITE_REG, FC_READ_EXC_ST, FC_DIAG,
					FC_WRITE_COILS, FC_WRITE_REGS, FC_READ_FILE, FC_MASK_WRITE,
					FC_RW_REGS, FC_READ_FIFO, FC_ENCAP: listed = 1'b1;
					default: listed = 1'b0;
				endcase
				r.kind = KIND_VERDICT;
				r.status = ST_OK;
				if (txn_err) begin
					r.status = ST_TXN;
				end else if (proto_err) begin
					r.status = ST_PROTOCOL;
				end else if (rsp_fc >= EXC_FLAG && len == hdr_len + 2 &&
					req_fc == rsp_fc - EXC_FLAG) begin
					if (rsp_count_byte >= EXC_CODE_MIN && rsp_count_byte <= EXC_CODE_MAX &&
						rsp_count_byte != EXC_CODE_SPARE) begin
						r.status = ST_EXCEPTION;
						r.exc = rsp_count_byte;
					end else begin
						r.status = ST_BAD_EXC;
					end
				end else if (len != reply_length(req_fc, req_qty, hdr_len)) begin
					r.status = ST_LENGTH;
				end else if (!listed) begin
					r.status = ST_BAD_FUNC;
				end else if (req_fc != rsp_fc) begin
					r.status = ST_FUNC_MISM;
				end else begin
					case (rsp_fc)
						FC_READ_COILS, FC_READ_DISCRETE: begin
							want = coil_bytes(req_qty);
							got = rsp_count_byte;
						end
						FC_READ_HOLDING, FC_READ_INPUT, FC_RW_REGS: begin
							want = req_qty;
							got = rsp_count_byte >> 1;
						end
						FC_WRITE_COILS, FC_WRITE_REGS: begin
							want = req_qty;
							got = rsp_qty_word;
						end
						FC_WRITE_COIL, FC_WRITE_REG: begin
							want = 1;
							got = 1;
						end
						default: ;
					endcase
					if (want != got) r.status = ST_QTY_MISM;
					else r.cnt = COUNT_W'(want);
				end
				awaited_reports.push_back(r);
			end
		end
	endtask

	task automatic send_byte(input logic op, input logic [7:0] b, input logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		opcode <= op;
		data_byte <= b;
		is_last <= last;
		do @(posedge clk); while (!in_ready);
		track_frames(op, b, last);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic op, input byte_q_t frame, input logic closed);
		foreach (frame[k]) send_byte(op, frame[k], closed && (k == frame.size() - 1));
	endtask

	task automatic write_header(input logic [2:0] h);
		in_valid <= 1'b0;
		burst_left = 0;
		while (awaited_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		hdr_len = h;
	endtask

	task automatic make_request(input logic [15:0] txn, input logic [7:0] fc,
		input logic [15:0] qty, input int unsigned extra, output byte_q_t rq);
		int unsigned k;
		rq = {};
		repeat (hdr_len + 5 + extra) rq.push_back(8'($urandom));
		rq[0] = txn[15:8];
		rq[1] = txn[7:0];
		for (k = 2; k < 4 && k < hdr_len; k++) rq[k] = 8'h00;
		rq[hdr_len] = fc;
		rq[hdr_len + 3] = qty[15:8];
		rq[hdr_len + 4] = qty[7:0];
	endtask

	task automatic build_reply(input byte_q_t rq, input logic [7:0] fc, input logic [15:0] qty,
		input int unsigned len, output byte_q_t rs);
		int unsigned k;
		rs = {};
		repeat (len) rs.push_back(8'($urandom));
		for (k = 0; k < len && k < hdr_len; k++) begin
			if (k < 2) rs[k] = rq[k];
			else if (k < 4) rs[k] = 8'h00;
		end
		for (k = 1; k <= 4; k++) begin
			if (hdr_len + k < len && hdr_len + k < rq.size()) rs[hdr_len + k] = rq[hdr_len + k];
		end
		if (hdr_len < len) rs[hdr_len] = fc;
		if (hdr_len + 1 < len) begin
			case (fc)
				FC_READ_COILS, FC_READ_DISCRETE: rs[hdr_len + 1] = 8'(coil_bytes(qty));
				FC_READ_HOLDING, FC_READ_INPUT, FC_RW_REGS: rs[hdr_len + 1] = 8'(2 * qty);
				default: ;
			endcase
		end
	endtask

	task automatic clean_exchange(input logic [7:0] fc, input logic [15:0] qty,
		input int unsigned extra);
		byte_q_t req_bytes;
		byte_q_t rsp_bytes;
		make_request(16'($urandom), fc, qty, extra, req_bytes);
		send_frame(OP_REQUEST, req_bytes, 1'b1);
		build_reply(req_bytes, fc, qty, reply_length(fc, qty, hdr_len), rsp_bytes);
		send_frame(OP_RESPONSE, rsp_bytes, 1'b1);
	endtask

	task automatic run_transaction();
		byte_q_t     req_bytes;
		byte_q_t     rsp_bytes;
		logic [7:0]  fc;
		logic [15:0] qty;
		int unsigned flaw;
		int unsigned len;
		int unsigned k;
		case ($urandom_range(0, 17))
			0: fc = FC_READ_COILS;
			1: fc = FC_READ_DISCRETE;
			2: fc = FC_READ_HOLDING;
			3: fc = FC_READ_INPUT;
			4: fc = FC_WRITE_COIL;
			5: fc = FC_WRITE_REG;
			6: fc = FC_READ_EXC_ST;
			7: fc = FC_DIAG;
			8: fc = FC_WRITE_COILS;
			9: fc = FC_WRITE_REGS;
			10: fc = FC_READ_FILE;
			11: fc = FC_MASK_WRITE;
			12: fc = FC_RW_REGS;
			13: fc = FC_READ_FIFO;
			14: fc = FC_ENCAP;
			default: fc = 8'($urandom);
		endcase
		case (fc)
			FC_READ_COILS, FC_READ_DISCRETE: qty = 16'($urandom_range(0, 96));
			FC_READ_HOLDING, FC_READ_INPUT, FC_RW_REGS: qty = 16'($urandom_range(0, 24));
			default: qty = 16'($urandom);
		endcase
		if ($urandom_range(0, 9) == 0) qty = 16'($urandom);
		make_request(16'($urandom), fc, qty,
			($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 0, req_bytes);
		send_frame(OP_REQUEST, req_bytes, 1'b1);
		flaw = $urandom_range(0, 11);
		if (flaw == 10) return;
		if (flaw == 5) begin
			build_reply(req_bytes, fc | EXC_FLAG, qty, hdr_len + 2, rsp_bytes);
			rsp_bytes[hdr_len + 1] = ($urandom_range(0, 2) != 0) ?
				8'($urandom_range(EXC_CODE_MIN, EXC_CODE_MAX)) : 8'($urandom);
			if ($urandom_range(0, 3) == 0) rsp_bytes.push_back(8'($urandom));
			send_frame(OP_RESPONSE, rsp_bytes, 1'b1);
			return;
		end
		len = reply_length(fc, qty, hdr_len);
		if (len <= hdr_len || len > 64) len = hdr_len + $urandom_range(1, 8);
		build_reply(req_bytes, fc, qty, len, rsp_bytes);
		case (flaw)
			6: begin
				k = (rsp_bytes.size() > 1) ? $urandom_range(0, 1) : 0;
				rsp_bytes[k] = rsp_bytes[k] ^ 8'($urandom_range(1, 255));
			end
			7: begin
				if (rsp_bytes.size() > 3)
					rsp_bytes[$urandom_range(2, 3)] = 8'($urandom_range(1, 255));
			end
			8: begin
				if ($urandom_range(0, 1) == 0 && rsp_bytes.size() > 1) rsp_bytes.pop_back();
				else rsp_bytes.push_back(8'($urandom));
			end
			9: begin
				k = hdr_len + $urandom_range(0, 2) * 2;
				if (k > hdr_len) k = k - 1;
				if (k < rsp_bytes.size()) rsp_bytes[k] = rsp_bytes[k] ^ 8'($urandom_range(1, 255));
			end
			default: ;
		endcase
		send_frame(OP_RESPONSE, rsp_bytes, flaw != 11);
	endtask

	task automatic report_failure(input string why, input report_t want, input report_t seen);
		mismatches++;
		if (mismatches <= 10)
			$display("%s at %0t: expected kind %0d status %0d code 0x%02h count %0d;",
				why, $time, want.kind, want.status, want.exc, want.cnt,
				" got kind %0d status %0d code 0x%02h count %0d",
				seen.kind, seen.status, seen.exc, seen.cnt);
	endtask

	always @(posedge clk) begin : result_check
		report_t seen;
		report_t want;
		if (out_valid === 1'b1 && out_ready) begin
			seen.kind = result_kind;
			seen.status = status;
			seen.exc = exc_code;
			seen.cnt = count;
			if (awaited_reports.size() == 0) begin
				report_failure("unexpected result", '0, seen);
			end else begin
				want = awaited_reports.pop_front();
				if (seen.kind !== want.kind || seen.status !== want.status ||
					seen.exc !== want.exc || seen.cnt !== want.cnt)
					report_failure("result mismatch", want, seen);
			end
		end
	end

	always @(posedge clk) begin
		if (ready_hold == 0) begin
			ready_style = $urandom_range(0, 3);
			ready_hold = $urandom_range(50, 300);
		end
		ready_hold--;
		ready_tick++;
		case (ready_style)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ((ready_tick % 5) < 2);
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	task automatic test_directed();
		byte_q_t frame;
		frame = {8'h00, 8'h00};
		send_frame(OP_RESPONSE, frame, 1'b1);
		frame = {8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h06, 8'h01, FC_RW_REGS,
			8'h00, 8'h00, 8'hFF, 8'hFF};
		send_frame(OP_REQUEST, frame, 1'b1);
		frame = {8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h03, 8'h01, FC_RW_REGS | EXC_FLAG,
			EXC_CODE_MAX};
		send_frame(OP_RESPONSE, frame, 1'b1);
		write_header(3'd0);
		frame = {FC_READ_COILS, 8'h00, 8'h00, 8'h00, 8'h08};
		send_frame(OP_REQUEST, frame, 1'b1);
		frame = {FC_READ_COILS, 8'h00, 8'h00};
		send_frame(OP_RESPONSE, frame, 1'b1);
	endtask

	task automatic test_long_frames();
		write_header(3'd7);
		clean_exchange(FC_READ_HOLDING, 16'd125, 0);
		clean_exchange(FC_READ_HOLDING, 16'd127, 0);
		clean_exchange(FC_WRITE_REGS, 16'($urandom), 260);
	endtask

	task automatic test_header_sweep();
		byte_q_t     junk;
		int unsigned first;
		int unsigned phase;
		logic [2:0]  h;
		first = bytes_sent;
		phase = 0;
		while (bytes_sent - first < SWEEP_BYTES) begin
			if (phase < 8) h = 3'((phase * 5 + 7) % 8);
			else if ($urandom_range(0, 1) == 0) h = 3'd7;
			else h = 3'($urandom_range(0, 7));
			write_header(h);
			phase++;
			repeat ($urandom_range(3, 8)) begin
				if ($urandom_range(0, 4) != 0) begin
					run_transaction();
				end else begin
					junk = {};
					repeat ($urandom_range(1, 10)) junk.push_back(8'($urandom));
					send_frame(1'($urandom_range(0, 1)), junk, $urandom_range(0, 3) != 0);
				end
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_long_frames();
		test_header_sweep();
		in_valid <= 1'b0;
		while (awaited_reports.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/mrc_pkg.sv
rtl/core/mrc_capture.sv
rtl/core/mrc_verdict.sv
rtl/core/modbus_response_checker.sv
verif/testbench.sv
